@@ design/ers_pkg.sv @@
// Shared types and constants for the elevator request scheduler.
// Used by every module of the block; no dependencies.
`default_nettype none

package ers_pkg;

  localparam int FLOOR_W  = 4;
  localparam int STATUS_W = 3;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_SERVE = 1'b1;

  localparam logic LIST_UP   = 1'b0;
  localparam logic LIST_DOWN = 1'b1;

  localparam logic [STATUS_W-1:0] ST_UP        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DOWN      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HERE      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MOVE_UP   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_MOVE_DOWN = 3'd5;
  localparam logic [STATUS_W-1:0] ST_IDLE      = 3'd6;

  typedef struct packed {
    logic vld;
    logic first;
    logic pick_max;
  } best_ctl_t;

endpackage

`default_nettype wire

@@ design/ers_ram.sv @@
// Request list memory holding both the up and the down list.
// One write port and one read port with registered read data; uses ers_pkg.
`default_nettype none

module ers_ram #(
  parameter int AW = 5
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [ers_pkg::FLOOR_W-1:0] wdata,
  input  wire logic [AW-1:0]               raddr,
  output logic      [ers_pkg::FLOOR_W-1:0] rdata_r
);

  logic [ers_pkg::FLOOR_W-1:0] mem_r [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

`default_nettype wire

@@ design/ers_best.sv @@
// Shared compare unit that tracks the smallest or largest floor of a scan.
// Keeps the first position of an equal extreme; uses ers_pkg.
`default_nettype none

module ers_best #(
  parameter int IW = 4
) (
  input  wire logic                        clk,
  input  wire ers_pkg::best_ctl_t          ctl,
  input  wire logic [ers_pkg::FLOOR_W-1:0] data,
  input  wire logic [IW-1:0]               pos,
  output logic      [ers_pkg::FLOOR_W-1:0] best_val_r,
  output logic      [IW-1:0]               best_pos_r
);

  logic better;

  always_comb begin
    if (ctl.pick_max) begin
      better = data > best_val_r;
    end else begin
      better = data < best_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.vld && (ctl.first || better)) begin
      best_val_r <= data;
      best_pos_r <= pos;
    end
  end

endmodule

`default_nettype wire

@@ design/elevator_request_scheduler.sv @@
// Top level of the elevator request scheduler for one car.
// Instantiates ers_ram and ers_best and holds the sequencer; uses ers_pkg.
//
// Input words carry an operation and a floor: an add stores the floor in the
// up or the down list, a serve removes the smallest up-list floor, or the
// largest down-list floor when the up list is empty, and moves the car there.
// Every input word yields exactly one output word with a status, the target
// floor and the distance moved.
// An add, and a serve with both lists empty, completes in the cycle it is
// accepted and its result shows in the cycle after. A serve of a list with n
// entries scans the list through the shared compare unit, then closes the
// gap behind the removed entry by moving each later entry down one place,
// and finishes in a last state that waits for the output register to be free;
// scan and shift read one entry at a time through the single read port.
// The block takes one word at a time; in_tready is low while a serve is in
// progress or while a result waits in the output register that the receiver
// has not taken.
// After reset the car is on floor zero and both lists are empty; no memory
// clearing is needed.
`default_nettype none

module elevator_request_scheduler #(
  parameter int FLOOR_COUNT = 10,
  parameter int LIST_DEPTH  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // op[0], floor[4:1], zero [7:5]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata   // status[2:0], target_floor[6:3],
                                       // travel_floors[10:7], zero [15:11]
);

  localparam int FW    = ers_pkg::FLOOR_W;
  localparam int SW    = ers_pkg::STATUS_W;
  localparam int IW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int AW    = IW + 1;
  localparam int CW    = $clog2(LIST_DEPTH + 1);
  localparam int FCW   = $clog2(FLOOR_COUNT + 1);
  localparam int CMP_W = (FCW > FW) ? FCW : FW;

  localparam logic [CW-1:0]    DEPTH_C   = CW'(LIST_DEPTH);
  localparam logic [CMP_W-1:0] FLOOR_LIM = CMP_W'(FLOOR_COUNT);
  localparam logic [FW-1:0]    FLOOR_TOP = FW'(FLOOR_COUNT - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [FW-1:0]     car_r, car_nxt;
  logic [CW-1:0]     up_cnt_r, up_cnt_nxt;
  logic [CW-1:0]     dn_cnt_r, dn_cnt_nxt;
  logic              sel_r, sel_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              dv_r, dv_nxt;
  logic [IW-1:0]     dpos_r, dpos_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [SW-1:0]     status_r, status_nxt;
  logic [FW-1:0]     target_r, target_nxt;
  logic [FW-1:0]     travel_r, travel_nxt;

  logic              in_op;
  logic [FW-1:0]     in_floor;
  logic [FW-1:0]     fl_sat;
  logic              accept;
  logic              out_free;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [FW-1:0]     ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [FW-1:0]     ram_rdata;

  ers_pkg::best_ctl_t best_ctl;
  logic [FW-1:0]      best_val;
  logic [IW-1:0]      best_pos;

  ers_ram #(
    .AW(AW)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr  (ram_raddr),
    .rdata_r(ram_rdata)
  );

  ers_best #(
    .IW(IW)
  ) u_best (
    .clk       (clk),
    .ctl       (best_ctl),
    .data      (ram_rdata),
    .pos       (dpos_r),
    .best_val_r(best_val),
    .best_pos_r(best_pos)
  );

  assign in_op    = in_tdata[0];
  assign in_floor = in_tdata[4:1];
  assign fl_sat   = (CMP_W'(in_floor) >= FLOOR_LIM) ? FLOOR_TOP : in_floor;

  assign out_free  = !out_vld_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, travel_r, target_r, status_r};

  assign best_ctl.vld      = dv_r && (state_r == S_SCAN);
  assign best_ctl.first    = (dpos_r == '0);
  assign best_ctl.pick_max = (sel_r == ers_pkg::LIST_DOWN);

  always_comb begin
    state_nxt   = state_r;
    car_nxt     = car_r;
    up_cnt_nxt  = up_cnt_r;
    dn_cnt_nxt  = dn_cnt_r;
    sel_nxt     = sel_r;
    n_nxt       = n_r;
    cnt_nxt     = cnt_r;
    dv_nxt      = 1'b0;
    dpos_nxt    = dpos_r;
    out_vld_nxt = out_vld_r && !out_tready;
    status_nxt  = status_r;
    target_nxt  = target_r;
    travel_nxt  = travel_r;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = fl_sat;
    ram_raddr   = {sel_r, cnt_r[IW-1:0]};

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == ers_pkg::OP_ADD) begin
            out_vld_nxt = 1'b1;
            target_nxt  = car_r;
            travel_nxt  = '0;
            if (fl_sat > car_r) begin
              if (up_cnt_r >= DEPTH_C) begin
                status_nxt = ers_pkg::ST_FULL;
              end else begin
                status_nxt = ers_pkg::ST_UP;
                ram_we     = 1'b1;
                ram_waddr  = {ers_pkg::LIST_UP, up_cnt_r[IW-1:0]};
                up_cnt_nxt = up_cnt_r + 1'b1;
              end
            end else if (fl_sat < car_r) begin
              if (dn_cnt_r >= DEPTH_C) begin
                status_nxt = ers_pkg::ST_FULL;
              end else begin
                status_nxt = ers_pkg::ST_DOWN;
                ram_we     = 1'b1;
                ram_waddr  = {ers_pkg::LIST_DOWN, dn_cnt_r[IW-1:0]};
                dn_cnt_nxt = dn_cnt_r + 1'b1;
              end
            end else begin
              status_nxt = ers_pkg::ST_HERE;
            end
          end else if (up_cnt_r != '0) begin
            sel_nxt   = ers_pkg::LIST_UP;
            n_nxt     = up_cnt_r;
            cnt_nxt   = '0;
            state_nxt = S_SCAN;
          end else if (dn_cnt_r != '0) begin
            sel_nxt   = ers_pkg::LIST_DOWN;
            n_nxt     = dn_cnt_r;
            cnt_nxt   = '0;
            state_nxt = S_SCAN;
          end else begin
            out_vld_nxt = 1'b1;
            status_nxt  = ers_pkg::ST_IDLE;
            target_nxt  = car_r;
            travel_nxt  = '0;
          end
        end
      end
      S_SCAN: begin
        if (cnt_r < n_r) begin
          dv_nxt   = 1'b1;
          dpos_nxt = cnt_r[IW-1:0];
          cnt_nxt  = cnt_r + 1'b1;
        end else if (!dv_r) begin
          cnt_nxt   = CW'(best_pos) + 1'b1;
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (dv_r) begin
          ram_we    = 1'b1;
          ram_waddr = {sel_r, dpos_r - 1'b1};
          ram_wdata = ram_rdata;
        end
        if (cnt_r < n_r) begin
          dv_nxt   = 1'b1;
          dpos_nxt = cnt_r[IW-1:0];
          cnt_nxt  = cnt_r + 1'b1;
        end else if (!dv_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          target_nxt  = best_val;
          travel_nxt  = (best_val >= car_r) ? (best_val - car_r) : (car_r - best_val);
          car_nxt     = best_val;
          if (sel_r == ers_pkg::LIST_UP) begin
            status_nxt = ers_pkg::ST_MOVE_UP;
            up_cnt_nxt = up_cnt_r - 1'b1;
          end else begin
            status_nxt = ers_pkg::ST_MOVE_DOWN;
            dn_cnt_nxt = dn_cnt_r - 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      car_r     <= '0;
      up_cnt_r  <= '0;
      dn_cnt_r  <= '0;
      dv_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      car_r     <= car_nxt;
      up_cnt_r  <= up_cnt_nxt;
      dn_cnt_r  <= dn_cnt_nxt;
      dv_r      <= dv_nxt;
      out_vld_r <= out_vld_nxt;
    end
    sel_r    <= sel_nxt;
    n_r      <= n_nxt;
    cnt_r    <= cnt_nxt;
    dpos_r   <= dpos_nxt;
    status_r <= status_nxt;
    target_r <= target_nxt;
    travel_r <= travel_nxt;
  end

endmodule

`default_nettype wire
